/* sv/cfma_pkg.sv */
// ----------------------------------------------------------------------------
// Cylindrical FFT magnitude averager package
// Shared geometry constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cfma_pkg;

  localparam int SPAN_X  = 128;
  localparam int ROWS_Z  = 128;
  localparam int HALF_X  = SPAN_X / 2;
  localparam int CELLS   = HALF_X * ROWS_Z;
  localparam int IDX_W   = $clog2(CELLS);

  localparam int SUM_W   = 48;
  localparam int TALLY_W = 24;
  localparam int MEAN_W  = 32;
  localparam int MAG_W   = 32;
  localparam int WORD_W  = SUM_W + TALLY_W;
  localparam int FREQ_W  = 7;
  localparam int WGT_W   = 16;
  localparam logic [WGT_W-1:0] WGT_RESET = 16'd4096;

  localparam int R2_W    = 18;
  localparam int ROOT_W  = R2_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int RAD_W   = ROOT_W + 1;
  localparam int SQ_ITER = ROOT_W;
  localparam int SQC_W   = $clog2(SQ_ITER);
  localparam int DIV_ITER = SUM_W;
  localparam int DVC_W   = $clog2(DIV_ITER);

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SQUARE,
    ST_R2,
    ST_ROOT,
    ST_ADDR,
    ST_FETCH,
    ST_WAIT,
    ST_DIVIDE,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic square;
    logic root_start;
    logic root_step;
    logic addr_load;
    logic mem_read;
    logic acc_write;
    logic clr_write;
    logic sweep_write;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic addr_ok;
    logic root_done;
    logic div_done;
    logic sweep_done;
  } status_t;

endpackage

/* sv/cfma_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cfma_dp.sv */
// ----------------------------------------------------------------------------
// Averager datapath
// Radius arithmetic, iterative square root and divider, cell store access.
// ----------------------------------------------------------------------------
module cfma_dp
  import cfma_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 cfg_we_i,
  input  logic [WGT_W-1:0]     cfg_wdata_i,
  input  logic [1:0]           opcode_i,
  input  logic [FREQ_W-1:0]    freq_x_i,
  input  logic signed [FREQ_W-1:0] freq_y_i,
  input  logic signed [FREQ_W-1:0] freq_z_i,
  input  logic [MAG_W-1:0]     magnitude_i,
  input  logic [FREQ_W-1:0]    cell_column_i,
  input  logic [FREQ_W-1:0]    cell_row_i,
  output logic [MEAN_W-1:0]    mean_value_o,
  output logic [TALLY_W-1:0]   cell_count_o,
  output logic                 binned_o
);

  localparam logic [IDX_W-1:0]   ROWS_V    = IDX_W'(ROWS_Z);
  localparam logic [IDX_W-1:0]   LAST_CELL = IDX_W'(CELLS - 1);
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  logic [WGT_W-1:0] wgt_q;
  op_e              op_q;
  logic [FREQ_W-1:0] x_q, col_q, row_q;
  logic signed [FREQ_W-1:0] y_q, z_q;
  logic [MAG_W-1:0] mag_q;

  logic [2*FREQ_W-1:0] xx_q;
  logic [2*FREQ_W-2:0] yy_q;
  logic signed [2*FREQ_W-1:0] ysq;
  logic [2*FREQ_W-1:0] yprod;
  logic [2*FREQ_W+WGT_W-2:0] yw;
  logic [R2_W-1:0] r2;

  logic [R2_W-1:0]   v_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_q;
  logic [SQC_W-1:0]  sqc_q;
  logic [REM_W-1:0]  rem_t, trial;
  logic [RAD_W-1:0]  rad_acc;

  logic signed [11:0] zrow, dcol;
  logic [10:0]        rad_cell;
  logic               ok_acc, ok_cell, ok;
  logic [IDX_W-1:0]   addr_sel, addr_q;

  logic [WORD_W-1:0]  rdata;
  logic [SUM_W-1:0]   rsum;
  logic [TALLY_W-1:0] rtally;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_new;
  logic [TALLY_W-1:0] tally_new;

  logic [SUM_W-1:0]   dvd_q;
  logic [TALLY_W-1:0] dvs_q, drem_q;
  logic [TALLY_W:0]   drem_t;
  logic               qbit;
  logic [DVC_W-1:0]   dvc_q;
  logic [SUM_W-1:0]   quo_next;

  logic [IDX_W-1:0]   sweep_q;

  logic [MEAN_W-1:0]  res_mean_q, out_mean_q;
  logic [TALLY_W-1:0] res_count_q, out_count_q;
  logic               res_bin_q, out_bin_q;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [WORD_W-1:0]  wdata;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wgt_q <= WGT_RESET;
    end else if (cfg_we_i) begin
      wgt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NOP;
    end else if (cmd_i.capture) begin
      op_q <= op_e'(opcode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= freq_x_i;
      y_q   <= freq_y_i;
      z_q   <= freq_z_i;
      mag_q <= magnitude_i;
      col_q <= cell_column_i;
      row_q <= cell_row_i;
    end
  end

  // squares, then weighted y term
  assign ysq   = y_q * y_q;
  assign yprod = $unsigned(ysq);
  assign yw    = yy_q * wgt_q;
  assign r2    = R2_W'(xx_q) + R2_W'(yw[2*FREQ_W+WGT_W-2:12]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      xx_q <= x_q * x_q;
      yy_q <= yprod[2*FREQ_W-2:0];
    end
  end

  // digit-by-digit square root, two radicand bits per step
  assign rem_t = {rem_q[REM_W-3:0], v_q[R2_W-1:R2_W-2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqc_q <= '0;
    end else if (cmd_i.root_start) begin
      sqc_q <= '0;
    end else if (cmd_i.root_step) begin
      sqc_q <= sqc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_start) begin
      v_q    <= r2;
      root_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.root_step) begin
      v_q <= {v_q[R2_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // round to nearest: step up when the remainder exceeds the floor root
  assign rad_acc = RAD_W'(root_q) + RAD_W'(rem_q > REM_W'(root_q));

  assign zrow   = 12'(z_q) + 12'(ROWS_Z / 2);
  assign ok_acc = (rad_acc < RAD_W'(HALF_X)) && !zrow[11] && (zrow < 12'(ROWS_Z));

  assign dcol     = $signed({5'b0, col_q}) - 12'(HALF_X);
  assign rad_cell = dcol[11] ? 11'(-dcol) : dcol[10:0];
  assign ok_cell  = (rad_cell < 11'(HALF_X)) && ({4'b0, row_q} < 11'(ROWS_Z));

  always_comb begin
    ok       = 1'b0;
    addr_sel = '0;
    case (op_q)
      OP_ACC: begin
        ok       = ok_acc;
        addr_sel = IDX_W'(rad_acc) * ROWS_V + IDX_W'(zrow);
      end
      OP_READ, OP_CLEAR: begin
        ok       = ok_cell;
        addr_sel = IDX_W'(rad_cell) * ROWS_V + IDX_W'(row_q);
      end
      default: begin
        ok       = 1'b0;
        addr_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      addr_q <= addr_sel;
    end
  end

  // cell store: sum in the upper bits, tally in the lower bits
  assign rsum      = rdata[WORD_W-1:TALLY_W];
  assign rtally    = rdata[TALLY_W-1:0];
  assign sum_add   = {1'b0, rsum} + (SUM_W+1)'(mag_q);
  assign sum_new   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  assign tally_new = (rtally == TALLY_MAX) ? rtally : rtally + 1'b1;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = '0;
    if (cmd_i.sweep_write) begin
      we    = 1'b1;
      waddr = sweep_q;
    end else if (cmd_i.clr_write) begin
      we = 1'b1;
    end else if (cmd_i.acc_write) begin
      we    = 1'b1;
      wdata = {sum_new, tally_new};
    end
  end

  cfma_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.mem_read),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_write) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  // restoring divider, one quotient bit per step
  assign drem_t   = {drem_q, dvd_q[SUM_W-1]};
  assign qbit     = drem_t >= {1'b0, dvs_q};
  assign quo_next = {dvd_q[SUM_W-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvc_q <= '0;
    end else if (cmd_i.div_start) begin
      dvc_q <= '0;
    end else if (cmd_i.div_step) begin
      dvc_q <= dvc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q  <= rsum;
      dvs_q  <= rtally;
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= quo_next;
      drem_q <= qbit ? TALLY_W'(drem_t - {1'b0, dvs_q}) : drem_t[TALLY_W-1:0];
    end
  end

  // result under construction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_mean_q  <= '0;
      res_count_q <= '0;
      res_bin_q   <= 1'b0;
    end else if (cmd_i.acc_write) begin
      res_count_q <= tally_new;
      res_bin_q   <= 1'b1;
    end else if (cmd_i.div_start) begin
      res_count_q <= rtally;
    end else if (cmd_i.div_step && status_o.div_done && (dvs_q != '0)) begin
      res_mean_q <= (quo_next[SUM_W-1:MEAN_W] != '0) ? '1 : quo_next[MEAN_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mean_q  <= res_mean_q;
      out_count_q <= res_count_q;
      out_bin_q   <= res_bin_q;
    end
  end

  assign mean_value_o = out_mean_q;
  assign cell_count_o = out_count_q;
  assign binned_o     = out_bin_q;

  assign status_o.op         = op_q;
  assign status_o.addr_ok    = ok;
  assign status_o.root_done  = (sqc_q == SQC_W'(SQ_ITER - 1));
  assign status_o.div_done   = (dvc_q == DVC_W'(DIV_ITER - 1));
  assign status_o.sweep_done = (sweep_q == LAST_CELL);

endmodule

/* sv/cfma_ctrl.sv */
// ----------------------------------------------------------------------------
// Averager controller
// Sequences reset sweep, radius, store access, division and output transfer.
// ----------------------------------------------------------------------------
module cfma_ctrl
  import cfma_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_acc_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP:  if (status_i.sweep_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = in_op_acc_i ? ST_SQUARE : ST_ADDR;
      ST_SQUARE: state_d = ST_R2;
      ST_R2:     state_d = ST_ROOT;
      ST_ROOT:   if (status_i.root_done) state_d = ST_ADDR;
      ST_ADDR: begin
        if (!status_i.addr_ok) begin
          state_d = ST_DONE;
        end else if (status_i.op == OP_CLEAR) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH:  state_d = ST_WAIT;
      ST_WAIT:   state_d = (status_i.op == OP_READ) ? ST_DIVIDE : ST_DONE;
      ST_DIVIDE: if (status_i.div_done) state_d = ST_DONE;
      ST_CLEAR:  state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_SWEEP:  cmd_o.sweep_write = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SQUARE: cmd_o.square     = 1'b1;
      ST_R2:     cmd_o.root_start = 1'b1;
      ST_ROOT:   cmd_o.root_step  = 1'b1;
      ST_ADDR:   cmd_o.addr_load  = 1'b1;
      ST_FETCH:  cmd_o.mem_read   = 1'b1;
      ST_WAIT: begin
        cmd_o.acc_write = (status_i.op == OP_ACC);
        cmd_o.div_start = (status_i.op == OP_READ);
      end
      ST_DIVIDE: cmd_o.div_step  = 1'b1;
      ST_CLEAR:  cmd_o.clr_write = 1'b1;
      ST_DONE:   cmd_o.out_load  = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/cylindrical_fft_magnitude_averager_unit.sv */
// ----------------------------------------------------------------------------
// Cylindrical FFT magnitude averager
// Bins magnitude samples into (radius, z) cells, reads back cell means, clears cells.
// ----------------------------------------------------------------------------
// Accumulate runs a 9-step square root and a store read-modify-write; read runs
//   a 48-step divider. One item is in flight at a time; the next input transfer
//   can occur once the result is in the output register, while the result waits.
// Reset: asynchronous, active low; then sweep all 8192 cells to zero, one per
//   cycle, and accept no input until the sweep is done.
module cylindrical_fft_magnitude_averager_unit
  import cfma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: y_weight, Q4.12
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: freq_x[6:0], freq_y[13:7], freq_z[20:14], magnitude[52:21],
  //        cell_column[59:53], cell_row[66:60], zero fill[71:67]
  input  logic [71:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: mean_value[31:0], cell_count[55:32]
  output logic [55:0] m_axis_tdata,
  // tuser: binned[0]
  output logic        m_axis_tuser
);

  cmd_t    cmd;
  status_t status;

  logic [MEAN_W-1:0]  mean_value;
  logic [TALLY_W-1:0] cell_count;

  // Sequence each item through the shared square root, store and divider.
  cfma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_acc_i (s_axis_tuser == OP_ACC),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Unpack the transfer fields straight into the datapath capture registers.
  cfma_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (s_axis_tuser),
    .freq_x_i      (s_axis_tdata[6:0]),
    .freq_y_i      (s_axis_tdata[13:7]),
    .freq_z_i      (s_axis_tdata[20:14]),
    .magnitude_i   (s_axis_tdata[52:21]),
    .cell_column_i (s_axis_tdata[59:53]),
    .cell_row_i    (s_axis_tdata[66:60]),
    .mean_value_o  (mean_value),
    .cell_count_o  (cell_count),
    .binned_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {cell_count, mean_value};

endmodule

/* dv/tb_cylindrical_fft_magnitude_averager_unit.sv */
// ----------------------------------------------------------------------------
// Cylindrical FFT magnitude averager testbench
// Drives random and directed accumulate, read, clear and no-op items through
// the stream ports, predicts each result from a private copy of the cell
// stores and compares it field by field in a scoreboard.
// ----------------------------------------------------------------------------
module tb_cylindrical_fft_magnitude_averager_unit;
  import cfma_pkg::*;

  localparam logic [SUM_W-1:0] SUM_SAT = '1;
  localparam int          WDOG_MAX  = 40000;

  // Scoreboard: holds the cell stores and a queue of predicted results.
  class cell_scoreboard;
    logic [SUM_W-1:0]   sums   [CELLS];
    logic [TALLY_W-1:0] tallies[CELLS];
    logic [WGT_W-1:0]   weight;
    logic [56:0]        pending[$];
    int                 mismatches;

    function new();
      foreach (sums[i]) begin
        sums[i] = '0;
        tallies[i] = '0;
      end
      weight = WGT_RESET;
      mismatches = 0;
    endfunction

    static function logic [9:0] nearest_root(logic [31:0] v);
      logic [9:0] r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      if (v > r * r + r) r++;
      return r;
    endfunction

    // Predict the result of one accepted item and advance the stores.
    function void note_item(op_e op, logic [71:0] d);
      logic [6:0]  fx, col, row_in;
      logic signed [6:0] fy, fz;
      logic [31:0] mag, mean, r2;
      logic [23:0] cnt;
      logic        bin;
      logic [63:0] yy, acc;
      logic [9:0]  rad;
      int          row, dcol, idx;
      fx = d[6:0]; fy = d[13:7]; fz = d[20:14]; mag = d[52:21];
      col = d[59:53]; row_in = d[66:60];
      mean = 0; cnt = 0; bin = 0;
      if (op == OP_ACC) begin
        yy  = 64'(int'(fy) * int'(fy));
        r2  = 32'(fx) * 32'(fx) + 32'((yy * weight) >> 12);
        rad = nearest_root(r2);
        row = int'(fz) + ROWS_Z / 2;
        if (rad < HALF_X && row >= 0 && row < ROWS_Z) begin
          idx = rad * ROWS_Z + row;
          acc = 64'(sums[idx]) + mag;
          sums[idx] = (acc > SUM_SAT) ? SUM_SAT : acc[SUM_W-1:0];
          if (tallies[idx] != '1) tallies[idx]++;
          cnt = tallies[idx];
          bin = 1'b1;
        end
      end else if (op == OP_READ || op == OP_CLEAR) begin
        dcol = int'(col) - HALF_X;
        if (dcol < 0) dcol = -dcol;
        if (dcol < HALF_X && row_in < ROWS_Z) begin
          idx = dcol * ROWS_Z + row_in;
          if (op == OP_READ) begin
            cnt = tallies[idx];
            if (cnt != 0) begin
              acc = sums[idx] / cnt;
              mean = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
            end
          end else begin
            sums[idx] = '0;
            tallies[idx] = '0;
          end
        end
      end
      pending.push_back({bin, cnt, mean});
    endfunction

    function void check_result(logic [55:0] d, logic u);
      logic [56:0] e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", d, u);
        return;
      end
      e = pending.pop_front();
      if (e[31:0] != d[31:0] || e[55:32] != d[55:32] || e[56] != u) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: mean %h/%h count %h/%h binned %b/%b",
                   e[31:0], d[31:0], e[55:32], d[55:32], e[56], u);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  cell_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int wdog;

  always #2 clk_i = ~clk_i;

  cylindrical_fft_magnitude_averager_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Receiver: stall at random, check every output transfer.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles without any transfer once out of reset.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("cylindrical_fft_magnitude_averager_unit test failed");
      $finish;
    end
  end

  // Send one item: optional idle gap, then hold tvalid until the transfer.
  // tvalid stays high after the transfer until the next item or stop_input.
  task automatic send_item(op_e op, logic [71:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, d);
  endtask

  // Drop tvalid after the last item of a phase.
  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [71:0] pack_item(logic [6:0] fx, logic [6:0] fy,
      logic [6:0] fz, logic [31:0] mag, logic [6:0] col, logic [6:0] row);
    return {5'b0, row, col, mag, fz, fy, fx};
  endfunction

  // Drain outstanding results, let the block settle, then write y_weight.
  task automatic write_weight(logic [15:0] w);
    stop_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.weight = w;
  endtask

  // Random phase: mostly in-range accumulates on a few hot rows so that
  // reads hit populated cells; the rest is reads, clears and no-ops.
  task automatic random_items(int n);
    int k;
    logic [6:0] fx, fy, fz, col, row;
    logic [31:0] mag;
    op_e op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      op = (k < 60) ? OP_ACC : (k < 85) ? OP_READ : (k < 95) ? OP_CLEAR : OP_NOP;
      fx = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(12));
      fy = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(6) - 3);
      fz = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(2));
      mag = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
      col = ($urandom_range(3) == 0) ? 7'($urandom) : 7'(64 + $urandom_range(24) - 12);
      row = ($urandom_range(3) == 0) ? 7'($urandom) : 7'(64 + $urandom_range(2));
      send_item(op, pack_item(fx, fy, fz, mag, col, row));
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every opcode, out-of-range radius, edge rows,
    // bad read address, wide mean, clears and the no-op code.
    send_item(OP_ACC,  pack_item(7'd0, 7'd0, 7'd0, 32'hFFFF_FFFF, '0, '0));
    send_item(OP_ACC,  pack_item(7'd0, 7'd0, 7'd0, 32'hFFFF_FFFF, '0, '0));
    send_item(OP_READ, pack_item('0, '0, '0, '0, 7'd64, 7'd64));
    send_item(OP_ACC,  pack_item(7'd64, 7'd0, 7'd0, 32'd5, '0, '0));
    send_item(OP_ACC,  pack_item(7'd63, 7'h40, 7'h3F, 32'd7, '0, '0));
    send_item(OP_ACC,  pack_item(7'd3, 7'h7D, 7'h40, 32'd9, '0, '0));
    send_item(OP_ACC,  pack_item(7'd63, 7'd0, 7'h3F, 32'd11, '0, '0));
    send_item(OP_READ, pack_item('0, '0, '0, '0, 7'd127, 7'd127));
    send_item(OP_READ, pack_item('0, '0, '0, '0, 7'd1, 7'd127));
    send_item(OP_READ, pack_item('0, '0, '0, '0, 7'd0, 7'd64));
    send_item(OP_READ, pack_item('0, '0, '0, '0, 7'd64, 7'd0));
    send_item(OP_CLEAR, pack_item('0, '0, '0, '0, 7'd64, 7'd64));
    send_item(OP_READ, pack_item('0, '0, '0, '0, 7'd64, 7'd64));
    send_item(OP_CLEAR, pack_item('0, '0, '0, '0, 7'd0, 7'd0));
    send_item(OP_NOP,  pack_item('1, '1, '1, '1, '1, '1));
    send_item(OP_ACC,  pack_item(7'd2, 7'h7F, 7'h7F, 32'd1, 7'h7F, 7'h7F));

    write_weight(16'd0);
    send_item(OP_ACC, pack_item(7'd1, 7'h40, 7'd0, 32'd3, '0, '0));
    send_item(OP_READ, pack_item('0, '0, '0, '0, 7'd65, 7'd64));
    write_weight(16'hFFFF);
    send_item(OP_ACC, pack_item(7'd0, 7'd1, 7'd0, 32'd3, '0, '0));
    send_item(OP_ACC, pack_item(7'd0, 7'h40, 7'd0, 32'd3, '0, '0));

    write_weight(16'd4096);
    send_idle_pct = 7;  recv_idle_pct = 64;
    random_items(550);
    write_weight(16'd1024);
    send_idle_pct = 64; recv_idle_pct = 7;
    random_items(500);
    write_weight(16'(  $urandom));
    send_idle_pct = 0;  recv_idle_pct = 0;
    random_items(530);

    stop_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("cylindrical_fft_magnitude_averager_unit test passed");
    else
      $display("cylindrical_fft_magnitude_averager_unit test failed");
    $finish;
  end
endmodule
